// File: hw/rtl/matrix_inverse_3x3_defines.svh
// Assertion helpers used by the top-level RTL.
`ifndef MATRIX_INVERSE_3X3_DEFINES_SVH
`define MATRIX_INVERSE_3X3_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define MI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define MI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/matinv_pkg.sv
package matinv_pkg;

  // Element format
  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int THR_W     = 31;
  localparam int NELEM     = 9;

  // Internal widths: products, cofactors, exact determinant magnitude
  localparam int PROD_W = 2 * ELEM_W;
  localparam int COF_W  = PROD_W + 1;
  localparam int CMAG_W = PROD_W;
  localparam int DET_W  = 3 * ELEM_W;
  localparam int SHIFT2 = 2 * FRAC_BITS;

  // Quotient bits kept before the overflow test takes over
  localparam int QBITS = ELEM_W + 1;

  // Pipeline depths
  localparam int FRONT_LAT = 9;
  localparam int LANE_LAT  = QBITS + 2;
  localparam int MERGE_LAT = 1;
  localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + MERGE_LAT;

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef struct packed {
    logic [CMAG_W-1:0] mag;
    logic              neg;
  } cof_t;

  typedef struct packed {
    logic  sing;
    logic  det_clip;
    elem_t det_out;
  } det_info_t;

endpackage

// File: hw/rtl/matinv_front.sv
module matinv_front (
  input  logic                                clk_i,
  input  matinv_pkg::elem_t                   a_i [matinv_pkg::NELEM],
  input  logic [matinv_pkg::THR_W-1:0]        thr_i,
  output matinv_pkg::cof_t                    cof_o [matinv_pkg::NELEM],
  output logic [matinv_pkg::DET_W-1:0]        det_mag_o,
  output logic                                det_neg_o,
  output matinv_pkg::det_info_t               info_o
);
  import matinv_pkg::*;

  // Cofactor i = a[CP]*a[CQ] - a[CS]*a[CU] (adjugate, row-major)
  localparam int CP [NELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int CQ [NELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int CS [NELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int CU [NELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // Row-0 expansion uses cofactors 0, 3 and 6
  localparam int CI [3] = '{0, 3, 6};

  logic signed [PROD_W-1:0] pp_q [NELEM];
  logic signed [PROD_W-1:0] pn_q [NELEM];
  elem_t                    a1_q [3];
  elem_t                    a2_q [3];
  logic signed [COF_W-1:0]  cof2_q [NELEM];
  cof_t                     cof3_q [NELEM];
  logic [ELEM_W-1:0]        am3_q [3];
  logic                     an3_q [3];
  logic [PROD_W-1:0]        lo4_q [3];
  logic [PROD_W-1:0]        hi4_q [3];
  logic                     tn4_q [3];
  logic [DET_W-1:0]         tm5_q [3];
  logic                     tn5_q [3];
  logic signed [DET_W+1:0]  ds6_d, ds6_q;
  logic [DET_W-1:0]         dm7_q, dm8_q, dm9_q;
  logic                     dn7_q, dn8_q, dn9_q;
  logic [DET_W:0]           rsum;
  logic [CMAG_W:0]          dr8_q;
  logic                     sg8_q;
  logic [CMAG_W:0]          dlim, dsel;
  logic                     dclip;
  det_info_t                info_q;
  cof_t                     cdl_q [FRONT_LAT-3][NELEM];

  // Stage 1: the eighteen products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NELEM; i++) begin
      pp_q[i] <= a_i[CP[i]] * a_i[CQ[i]];
      pn_q[i] <= a_i[CS[i]] * a_i[CU[i]];
    end
    for (int k = 0; k < 3; k++) begin
      a1_q[k] <= a_i[k];
    end
  end

  // Stage 2: cofactors, exact
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NELEM; i++) begin
      cof2_q[i] <= {pp_q[i][PROD_W-1], pp_q[i]} - {pn_q[i][PROD_W-1], pn_q[i]};
    end
    a2_q <= a1_q;
  end

  // Stage 3: sign and magnitude
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NELEM; i++) begin
      cof3_q[i].neg <= cof2_q[i][COF_W-1];
      cof3_q[i].mag <= cof2_q[i][COF_W-1] ? CMAG_W'(-cof2_q[i]) : CMAG_W'(cof2_q[i]);
    end
    for (int k = 0; k < 3; k++) begin
      an3_q[k] <= a2_q[k][ELEM_W-1];
      am3_q[k] <= a2_q[k][ELEM_W-1] ? ELEM_W'(-a2_q[k]) : ELEM_W'(a2_q[k]);
    end
  end

  // Stage 4: 32x64 products split into two 32x32 halves
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      lo4_q[k] <= am3_q[k] * cof3_q[CI[k]].mag[ELEM_W-1:0];
      hi4_q[k] <= am3_q[k] * cof3_q[CI[k]].mag[CMAG_W-1:ELEM_W];
      tn4_q[k] <= an3_q[k] ^ cof3_q[CI[k]].neg;
    end
  end

  // Stage 5: join halves
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      tm5_q[k] <= {hi4_q[k], {ELEM_W{1'b0}}} + {{ELEM_W{1'b0}}, lo4_q[k]};
    end
    tn5_q <= tn4_q;
  end

  // Stage 6: signed sum of the three terms
  always_comb begin
    ds6_d = '0;
    for (int k = 0; k < 3; k++) begin
      if (tn5_q[k]) begin
        ds6_d = ds6_d - {2'b00, tm5_q[k]};
      end else begin
        ds6_d = ds6_d + {2'b00, tm5_q[k]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ds6_q <= ds6_d;
  end

  // Stage 7: determinant magnitude
  always_ff @(posedge clk_i) begin
    dn7_q <= ds6_q[DET_W+1];
    dm7_q <= ds6_q[DET_W+1] ? DET_W'(-ds6_q) : ds6_q[DET_W-1:0];
  end

  // Stage 8: singular test and rounding add
  assign rsum = {1'b0, dm7_q} + ((DET_W + 1)'(1) << (SHIFT2 - 1));

  always_ff @(posedge clk_i) begin
    sg8_q <= (dm7_q == '0) || (dm7_q < (DET_W'(thr_i) << SHIFT2));
    dr8_q <= (CMAG_W + 1)'(rsum >> SHIFT2);
    dm8_q <= dm7_q;
    dn8_q <= dn7_q;
  end

  // Stage 9: saturate the rounded determinant
  always_comb begin
    dlim  = dn8_q ? ((CMAG_W + 1)'(1) << (ELEM_W - 1))
                  : ((CMAG_W + 1)'(1) << (ELEM_W - 1)) - 1'b1;
    dclip = dr8_q > dlim;
    dsel  = dclip ? dlim : dr8_q;
  end

  always_ff @(posedge clk_i) begin
    info_q.sing     <= sg8_q;
    info_q.det_clip <= dclip;
    info_q.det_out  <= dn8_q ? ELEM_W'(-dsel) : ELEM_W'(dsel);
    dm9_q           <= dm8_q;
    dn9_q           <= dn8_q;
  end

  // Cofactors wait for the determinant
  always_ff @(posedge clk_i) begin
    cdl_q[0] <= cof3_q;
    for (int j = 1; j < FRONT_LAT - 3; j++) begin
      cdl_q[j] <= cdl_q[j-1];
    end
  end

  assign cof_o     = cdl_q[FRONT_LAT-4];
  assign det_mag_o = dm9_q;
  assign det_neg_o = dn9_q;
  assign info_o    = info_q;

endmodule

// File: hw/rtl/matinv_lane.sv
module matinv_lane (
  input  logic                          clk_i,
  input  matinv_pkg::cof_t              cof_i,
  input  logic [matinv_pkg::DET_W-1:0]  det_mag_i,
  input  logic                          det_neg_i,
  output matinv_pkg::elem_t             b_o,
  output logic                          clip_o
);
  import matinv_pkg::*;

  logic [DET_W-1:0] rem_q [QBITS+1];
  logic [DET_W-1:0] d_q   [QBITS+1];
  logic [QBITS-1:0] q_q   [QBITS+1];
  logic             neg_q [QBITS+1];
  logic             ovf_q [QBITS+1];
  logic             lsb_q;
  logic             half;
  logic [QBITS:0]   qr, lim, msel;
  logic             clip;
  elem_t            b_q;
  logic             clip_q;

  // Entry: numerator is cof << 2F; quotient of 2^QBITS or more saturates
  always_ff @(posedge clk_i) begin
    rem_q[0] <= DET_W'(cof_i.mag >> 1);
    lsb_q    <= cof_i.mag[0];
    d_q[0]   <= det_mag_i;
    q_q[0]   <= '0;
    neg_q[0] <= cof_i.neg ^ det_neg_i;
    ovf_q[0] <= {{(DET_W + 1 - CMAG_W){1'b0}}, cof_i.mag} >= {det_mag_i, 1'b0};
  end

  // One restoring step per stage, MSB of the quotient first
  for (genvar k = 1; k <= QBITS; k++) begin : g_step
    logic             bin;
    logic [DET_W:0]   trial;
    logic             ge;

    assign bin   = (k == 1) ? lsb_q : 1'b0;
    assign trial = {rem_q[k-1], bin};
    assign ge    = trial >= {1'b0, d_q[k-1]};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DET_W'(trial - {1'b0, d_q[k-1]}) : trial[DET_W-1:0];
      q_q[k]   <= {q_q[k-1][QBITS-2:0], ge};
      d_q[k]   <= d_q[k-1];
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
  end

  // Round half away from zero, then saturate
  always_comb begin
    half = {rem_q[QBITS], 1'b0} >= {1'b0, d_q[QBITS]};
    qr   = {1'b0, q_q[QBITS]} + (QBITS + 1)'(half);
    lim  = neg_q[QBITS] ? ((QBITS + 1)'(1) << (ELEM_W - 1))
                        : ((QBITS + 1)'(1) << (ELEM_W - 1)) - 1'b1;
    clip = ovf_q[QBITS] || (qr > lim);
    msel = clip ? lim : qr;
  end

  always_ff @(posedge clk_i) begin
    b_q    <= neg_q[QBITS] ? ELEM_W'(-msel) : ELEM_W'(msel);
    clip_q <= clip;
  end

  assign b_o    = b_q;
  assign clip_o = clip_q;

endmodule

// File: hw/rtl/matinv_merge.sv
module matinv_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  matinv_pkg::elem_t       b_i    [matinv_pkg::NELEM],
  input  logic                    clip_i [matinv_pkg::NELEM],
  input  matinv_pkg::det_info_t   info_i,
  output matinv_pkg::elem_t       b_o    [matinv_pkg::NELEM],
  output matinv_pkg::elem_t       det_o,
  output logic                    sing_o,
  output logic                    sat_o,
  output logic                    done_o
);
  import matinv_pkg::*;

  logic  any_clip;
  elem_t b_q [NELEM];
  elem_t det_q;
  logic  sing_q, sat_q, done_q;

  // Lane clips only count for a regular matrix
  always_comb begin
    any_clip = 1'b0;
    for (int i = 0; i < NELEM; i++) begin
      any_clip = any_clip | clip_i[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NELEM; i++) begin
      b_q[i] <= info_i.sing ? '0 : b_i[i];
    end
    det_q  <= info_i.det_out;
    sing_q <= info_i.sing;
    sat_q  <= info_i.det_clip | (~info_i.sing & any_clip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_i;
    end
  end

  assign b_o    = b_q;
  assign det_o  = det_q;
  assign sing_o = sing_q;
  assign sat_o  = sat_q;
  assign done_o = done_q;

endmodule

// File: hw/rtl/matrix_inverse_3x3.sv
// 3x3 inverse in signed Q16.16 by the adjugate over the determinant. A matrix is
// taken on any cycle with start high (busy stays low), so one matrix per clock is
// sustained. Each result is shown for exactly one cycle with done_o high, after
// passing the cofactor and determinant front end, the nine dividers (one quotient
// bit per pipeline stage) and one output register; the receiver cannot stall, so
// it must take every result then. The threshold may only be written while no
// matrix is in flight.
`include "matrix_inverse_3x3_defines.svh"

module matrix_inverse_3x3 (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [31:0]             a00_i,
  input  logic signed [31:0]             a01_i,
  input  logic signed [31:0]             a02_i,
  input  logic signed [31:0]             a10_i,
  input  logic signed [31:0]             a11_i,
  input  logic signed [31:0]             a12_i,
  input  logic signed [31:0]             a20_i,
  input  logic signed [31:0]             a21_i,
  input  logic signed [31:0]             a22_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [matinv_pkg::THR_W-1:0]   cfg_data_i,
  output logic                           done_o,
  output logic signed [31:0]             b00_o,
  output logic signed [31:0]             b01_o,
  output logic signed [31:0]             b02_o,
  output logic signed [31:0]             b10_o,
  output logic signed [31:0]             b11_o,
  output logic signed [31:0]             b12_o,
  output logic signed [31:0]             b20_o,
  output logic signed [31:0]             b21_o,
  output logic signed [31:0]             b22_o,
  output logic signed [31:0]             determinant_o,
  output logic                           singular_o,
  output logic                           saturated_o
);
  import matinv_pkg::*;

  localparam int VLD_LEN = FRONT_LAT + LANE_LAT;

  elem_t            a    [NELEM];
  cof_t             cof  [NELEM];
  elem_t            lb   [NELEM];
  logic             lclip[NELEM];
  elem_t            ob   [NELEM];
  logic [DET_W-1:0] det_mag;
  logic             det_neg;
  det_info_t        info;
  det_info_t        inf_q [LANE_LAT];
  logic [VLD_LEN-1:0] vld_q;
  logic [THR_W-1:0] thr_q;
  logic             acc;

  assign busy        = 1'b0;
  assign acc         = start & ~busy;
  assign cfg_ready_o = 1'b1;

  assign a = '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // Item valid travels alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[VLD_LEN-2:0], acc};
    end
  end

  matinv_front u_front (
    .clk_i     (clk_i),
    .a_i       (a),
    .thr_i     (thr_q),
    .cof_o     (cof),
    .det_mag_o (det_mag),
    .det_neg_o (det_neg),
    .info_o    (info)
  );

  // Nine divider lanes
  for (genvar i = 0; i < NELEM; i++) begin : g_lane
    matinv_lane u_lane (
      .clk_i     (clk_i),
      .cof_i     (cof[i]),
      .det_mag_i (det_mag),
      .det_neg_i (det_neg),
      .b_o       (lb[i]),
      .clip_o    (lclip[i])
    );
  end

  // Determinant result waits for the lanes
  always_ff @(posedge clk_i) begin
    inf_q[0] <= info;
    for (int j = 1; j < LANE_LAT; j++) begin
      inf_q[j] <= inf_q[j-1];
    end
  end

  matinv_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (vld_q[VLD_LEN-1]),
    .b_i    (lb),
    .clip_i (lclip),
    .info_i (inf_q[LANE_LAT-1]),
    .b_o    (ob),
    .det_o  (determinant_o),
    .sing_o (singular_o),
    .sat_o  (saturated_o),
    .done_o (done_o)
  );

  assign b00_o = ob[0];
  assign b01_o = ob[1];
  assign b02_o = ob[2];
  assign b10_o = ob[3];
  assign b11_o = ob[4];
  assign b12_o = ob[5];
  assign b20_o = ob[6];
  assign b21_o = ob[7];
  assign b22_o = ob[8];

  // Checks
  `MI_ASSERT_IMP(a_done_lat, done_o, $past(acc, TOTAL_LAT), "result without a matching start")
  `MI_ASSERT_IMP(a_sing_zero, done_o && singular_o, b00_o == 0 && b01_o == 0 && b11_o == 0 && b22_o == 0, "singular result not zero")
  `MI_ASSERT_NXT(a_det_sat, vld_q[VLD_LEN-1] && inf_q[LANE_LAT-1].det_clip, saturated_o, "determinant clip lost")

endmodule

// File: dv/matrix_inverse_3x3_tb.sv
module matrix_inverse_3x3_tb;
  import matinv_pkg::*;

  typedef struct {
    elem_t inv [9];
    elem_t det;
    logic  sing;
    logic  sat;
  } inv_res_t;

  typedef struct {
    elem_t    m [9];
    logic     has_exp;
    inv_res_t exp_res;
  } stim_row_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = TOTAL_LAT + 20;
  localparam int N_RANDOM    = 100;
  localparam elem_t ONE      = 32'sh0001_0000;
  localparam elem_t EMAX     = 32'sh7fff_ffff;
  localparam elem_t EMIN     = 32'sh8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  elem_t a_in [9];
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i = '0;
  logic done_o;
  elem_t b_out [9];
  elem_t determinant_o;
  logic singular_o, saturated_o;

  inv_res_t expected_q [$];
  logic [THR_W-1:0] cur_thr;
  int n_mismatch = 0;
  int cycles = 0;
  int burst_left = 0;
  stim_row_t rows [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial for (int i = 0; i < 9; i++) a_in[i] = '0;

  matrix_inverse_3x3 dut (
    .clk_i, .rst_ni, .start, .busy,
    .a00_i(a_in[0]), .a01_i(a_in[1]), .a02_i(a_in[2]),
    .a10_i(a_in[3]), .a11_i(a_in[4]), .a12_i(a_in[5]),
    .a20_i(a_in[6]), .a21_i(a_in[7]), .a22_i(a_in[8]),
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o,
    .b00_o(b_out[0]), .b01_o(b_out[1]), .b02_o(b_out[2]),
    .b10_o(b_out[3]), .b11_o(b_out[4]), .b12_o(b_out[5]),
    .b20_o(b_out[6]), .b21_o(b_out[7]), .b22_o(b_out[8]),
    .determinant_o, .singular_o, .saturated_o
  );

  // Exact adjugate inverse: cofactors and determinant kept at full width
  function automatic inv_res_t invert3(elem_t m [9], logic [THR_W-1:0] thr);
    logic signed [127:0] x [9];
    logic signed [127:0] c [9];
    logic signed [127:0] dt;
    logic [127:0] dmag, nmag, q, r, lim;
    logic dneg, cneg, qneg;
    inv_res_t res;
    for (int i = 0; i < 9; i++) x[i] = m[i];
    c[0] = x[4] * x[8] - x[5] * x[7];
    c[1] = x[2] * x[7] - x[1] * x[8];
    c[2] = x[1] * x[5] - x[2] * x[4];
    c[3] = x[5] * x[6] - x[3] * x[8];
    c[4] = x[0] * x[8] - x[2] * x[6];
    c[5] = x[2] * x[3] - x[0] * x[5];
    c[6] = x[3] * x[7] - x[4] * x[6];
    c[7] = x[1] * x[6] - x[0] * x[7];
    c[8] = x[0] * x[4] - x[1] * x[3];
    dt = x[0] * c[0] + x[1] * c[3] + x[2] * c[6];
    dneg = dt < 0;
    dmag = dneg ? -dt : dt;
    res.sat = 1'b0;
    res.sing = (dmag == 0) || (dmag < ({97'd0, thr} << SHIFT2));
    // determinant back to Q16.16, half away from zero
    q = (dmag + (128'd1 << (SHIFT2 - 1))) >> SHIFT2;
    lim = dneg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
    if (q > lim) begin
      q = lim;
      res.sat = 1'b1;
    end
    res.det = dneg ? -q[31:0] : q[31:0];
    for (int i = 0; i < 9; i++) begin
      if (res.sing) begin
        res.inv[i] = '0;
      end else begin
        cneg = c[i] < 0;
        nmag = (cneg ? -c[i] : c[i]) << SHIFT2;
        q = nmag / dmag;
        r = nmag % dmag;
        if ((r << 1) >= dmag) q = q + 1;
        qneg = cneg ^ dneg;
        lim = qneg ? (128'd1 << 31) : ((128'd1 << 31) - 1);
        if (q > lim) begin
          q = lim;
          res.sat = 1'b1;
        end
        res.inv[i] = qneg ? -q[31:0] : q[31:0];
      end
    end
    return res;
  endfunction

  // Result checker: every strobe pops the oldest expectation
  always @(posedge clk_i) begin
    inv_res_t e;
    logic bad;
    if (done_o) begin
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transfer");
      end else begin
        e = expected_q.pop_front();
        bad = (e.det !== determinant_o) || (e.sing !== singular_o) ||
              (e.sat !== saturated_o);
        for (int i = 0; i < 9; i++) if (e.inv[i] !== b_out[i]) bad = 1'b1;
        if (bad) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch det exp %h got %h sing %b/%b sat %b/%b",
                     e.det, determinant_o, e.sing, singular_o, e.sat, saturated_o);
            for (int i = 0; i < 9; i++)
              $display("  b%0d%0d exp %h got %h", i / 3, i % 3, e.inv[i], b_out[i]);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_matrix(elem_t m [9], logic has_exp, inv_res_t exp_res);
    logic was_busy;
    // sender may idle between bursts
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    start <= 1'b1;
    for (int i = 0; i < 9; i++) a_in[i] <= m[i];
    do begin
      @(negedge clk_i) was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
    expected_q.push_back(has_exp ? exp_res : invert3(m, cur_thr));
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    logic rdy;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do begin
      @(negedge clk_i) rdy = cfg_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    cfg_valid_i <= 1'b0;
    cur_thr = thr;
  endtask

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 16)) - 8) <<< 16 |
                elem_t'($urandom_range(0, 65535));
      2: return elem_t'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom_range(0, 1) ? EMAX : EMIN;
    endcase
  endfunction

  task automatic random_items(int n);
    elem_t m [9];
    inv_res_t dummy;
    int kind, shape;
    for (int k = 0; k < n; k++) begin
      shape = $urandom_range(0, 9);
      kind = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 1;
      for (int i = 0; i < 9; i++)
        m[i] = ($urandom_range(0, 7) == 0) ? rand_elem($urandom_range(0, 3)) : rand_elem(kind);
      // near-singular: third row close to first
      if (shape == 0)
        for (int i = 0; i < 3; i++) m[6 + i] = m[i] + elem_t'($urandom_range(0, 3));
      // stronger diagonal: diagonal entries set between 4.0 and 60.0
      if (shape >= 7)
        for (int i = 0; i < 3; i++) m[4 * i] = elem_t'($urandom_range(4, 60)) <<< 16;
      send_matrix(m, 1'b0, dummy);
    end
  endtask

  function automatic stim_row_t diag_row(elem_t d0, elem_t d1, elem_t d2);
    stim_row_t r;
    for (int i = 0; i < 9; i++) r.m[i] = '0;
    r.m[0] = d0;
    r.m[4] = d1;
    r.m[8] = d2;
    r.has_exp = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t fill_row(elem_t v);
    stim_row_t r;
    for (int i = 0; i < 9; i++) r.m[i] = v;
    r.has_exp = 1'b0;
    return r;
  endfunction

  initial begin
    stim_row_t r;
    inv_res_t zres, ires;
    // directed table
    r = fill_row('0);
    r.has_exp = 1'b1;
    zres.det = '0; zres.sing = 1'b1; zres.sat = 1'b0;
    for (int i = 0; i < 9; i++) zres.inv[i] = '0;
    r.exp_res = zres;
    rows.push_back(r);
    r = diag_row(ONE, ONE, ONE);
    r.has_exp = 1'b1;
    ires = zres;
    ires.det = ONE; ires.sing = 1'b0;
    ires.inv[0] = ONE; ires.inv[4] = ONE; ires.inv[8] = ONE;
    r.exp_res = ires;
    rows.push_back(r);
    rows.push_back(fill_row(EMAX));
    rows.push_back(fill_row(EMIN));
    rows.push_back(diag_row(EMAX, EMAX, EMAX));
    rows.push_back(diag_row(EMIN, EMIN, EMIN));
    rows.push_back(diag_row(EMIN, EMAX, EMIN));
    rows.push_back(diag_row(32'sd1, 32'sd1, 32'sd1));
    rows.push_back(diag_row(32'sd1, EMAX, EMAX));
    rows.push_back(diag_row(-ONE, -ONE, -ONE));
    rows.push_back(diag_row(32'sd3, 32'sd3, 32'sd3));
    rows.push_back(diag_row(ONE <<< 1, -(ONE >>> 1), ONE * 3));
    rows.push_back(fill_row(32'shAAAA_AAAA));
    rows.push_back(fill_row(32'sh5555_5555));
    r = diag_row(32'shAAAA_AAAA, 32'sh5555_5555, 32'sh0000_ffff);
    r.m[1] = 32'sh5555_5555; r.m[5] = 32'shAAAA_AAAA;
    rows.push_back(r);
    r = diag_row('0, '0, ONE);    // row swap
    r.m[1] = ONE; r.m[3] = ONE;
    rows.push_back(r);
    r = diag_row(ONE, ONE, ONE);  // upper triangular with large off-diagonal
    r.m[1] = EMAX; r.m[2] = EMIN; r.m[5] = EMAX;
    rows.push_back(r);

    cur_thr = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) send_matrix(rows[k].m, rows[k].has_exp, rows[k].exp_res);
    random_items(N_RANDOM);
    drain();

    // zero threshold: only an exactly zero determinant is singular
    write_threshold('0);
    foreach (rows[k]) if (!rows[k].has_exp) send_matrix(rows[k].m, 1'b0, zres);
    random_items(N_RANDOM);
    drain();

    write_threshold({THR_W{1'b1}});
    random_items(N_RANDOM / 2);
    drain();

    write_threshold(THR_W'(ONE));
    random_items(N_RANDOM);
    drain();

    write_threshold(THR_W'($urandom));
    random_items(N_RANDOM);
    drain();

    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
